FILE: design/dgc_pkg.sv
// ---------------------------------------------------------------------------
// dgc_pkg: shared types and constants for the directed graph cycle check
// Holds the scan chunk geometry and the control group of the adjacency RAM.
// ---------------------------------------------------------------------------
package dgc_pkg;

  // bits of an adjacency row examined per scan cycle
  localparam int SCAN_W     = 8;
  localparam int SCAN_SHIFT = 3;

  // control group for the adjacency RAM
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } adj_ctl_t;

endpackage

FILE: design/dgc_adj_ram.sv
// ---------------------------------------------------------------------------
// dgc_adj_ram: adjacency bit matrix storage
// One row per node, one write and one registered read per cycle. Per-row
// valid bits let a batch clear empty every row; invalid rows read zero.
// ---------------------------------------------------------------------------
module dgc_adj_ram #(
  parameter int MAX_NODES = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dgc_pkg::adj_ctl_t            ctl,
  input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
  input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
  input  logic [MAX_NODES-1:0]         wr_data,
  output logic [MAX_NODES-1:0]         rd_data
);

  logic [MAX_NODES-1:0] mem [MAX_NODES];
  logic [MAX_NODES-1:0] rd_r;
  logic [MAX_NODES-1:0] row_vld_r;
  logic                 rd_vld_r;

  // row storage, synchronous read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  // row valid bits, cleared together at batch end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (ctl.clr) begin
        row_vld_r <= '0;
      end else if (ctl.wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld_r <= row_vld_r[rd_addr];
      end
    end
  end

  // a row never written in this batch reads as empty
  assign rd_data = rd_vld_r ? rd_r : '0;

endmodule

FILE: design/directed_graph_cycle_check.sv
// ---------------------------------------------------------------------------
// directed_graph_cycle_check: depth-first cycle detection over loaded edges
// Collects "from depends on to" edges into an adjacency RAM and, on the
// batch's last item, walks the graph depth first to report acyclicity.
// ---------------------------------------------------------------------------
// Usage:
//   cfg_*  : num_courses, written while the block is idle; cfg_ready is
//            always high. At most one node means every batch is acyclic.
//   in_*   : one edge item per cycle while loading (valid/stall). has_edge
//            low with last_edge high closes an empty batch. Items with
//            neither flag are dropped. Edge ids at or above MAX_NODES drop.
//   out_*  : one acyclic result per batch, held in an output register.
// Throughput: while in_stall is low, edges load one per cycle; a
//   read-modify-write of the row with forwarding keeps back-to-back
//   edges to the same row correct.
// Walk: a trivial batch (no edges, or num_courses <= 1) goes from flush to
//   result. Otherwise the walk uses the RAM's single read port: seek tries
//   each start node, each row fetch (push or return) passes the row state,
//   and the scan state steps per 8 row bits and per edge found.
// Input stall is high from the last item until its result is registered;
//   a stalled receiver holds the block in the result state.
// Reset: synchronous, empties the matrix, marks and num_courses.
// ---------------------------------------------------------------------------
module directed_graph_cycle_check #(
  parameter int MAX_NODES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_num_courses,
  // edge items
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [5:0] in_edge_from,
  input  logic [5:0] in_edge_to,
  input  logic       in_has_edge,
  input  logic       in_last_edge,
  // results
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_acyclic
);

  localparam int SCAN_W     = dgc_pkg::SCAN_W;
  localparam int SCAN_SHIFT = dgc_pkg::SCAN_SHIFT;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int DEP_W      = $clog2(MAX_NODES + 1);
  localparam int CUR_W      = ($clog2(MAX_NODES + 1) > SCAN_SHIFT) ?
                              $clog2(MAX_NODES + 1) : SCAN_SHIFT + 1;
  localparam int HI_W       = CUR_W - SCAN_SHIFT;
  localparam int NCHUNK     = (MAX_NODES + SCAN_W - 1) / SCAN_W;
  localparam int ROW_W      = NCHUNK * SCAN_W;
  localparam int STK_W      = NODE_W + CUR_W;

  typedef enum logic [2:0] {
    S_LOAD,
    S_FLUSH,
    S_SEEK,
    S_ROW,
    S_SCAN,
    S_POP,
    S_RESULT
  } state_t;

  state_t               state_r;
  logic [6:0]           num_courses_r;
  logic                 edge_seen_r;
  // load pipeline
  logic                 s1_vld_r;
  logic                 s1_fwd_r;
  logic [NODE_W-1:0]    s1_from_r;
  logic [NODE_W-1:0]    s1_to_r;
  logic [MAX_NODES-1:0] wr_data_r;
  // walk
  logic [MAX_NODES-1:0] on_path_r;
  logic [MAX_NODES-1:0] done_r;
  logic [DEP_W-1:0]     depth_r;
  logic [CUR_W-1:0]     start_r;
  logic [NODE_W-1:0]    top_node_r;
  logic [CUR_W-1:0]     top_cur_r;
  logic [ROW_W-1:0]     row_r;
  logic                 res_r;
  // walk stack
  logic [STK_W-1:0]     stk_mem [MAX_NODES];
  logic [STK_W-1:0]     stk_rd_r;
  logic                 stk_wr_en;
  logic                 stk_rd_en;
  logic [NODE_W-1:0]    stk_node;
  logic [CUR_W-1:0]     stk_cur;
  // output register
  logic                 out_valid_r;
  logic                 out_acyclic_r;

  // adjacency RAM port
  dgc_pkg::adj_ctl_t    adj_ctl;
  logic [NODE_W-1:0]    adj_rd_addr;
  logic [MAX_NODES-1:0] adj_merged;
  logic [MAX_NODES-1:0] adj_rd_data;

  // handshake terms
  logic                 in_acc;
  logic                 in_range;
  logic [NODE_W-1:0]    in_from_node;
  logic [NODE_W-1:0]    in_to_node;
  logic                 res_load;

  // scan terms
  logic [HI_W-1:0]       cur_hi;
  logic [SCAN_W-1:0]     chunk_bits;
  logic [SCAN_W-1:0]     chunk_masked;
  logic [SCAN_SHIFT-1:0] hit_off;
  logic                  cur_end;
  logic                  last_chunk;
  logic                  scan_found;
  logic                  scan_exhausted;
  logic [CUR_W-1:0]      m_cur;
  logic [CUR_W-1:0]      m_next;
  logic [CUR_W-1:0]      next_base;
  logic [NODE_W-1:0]     m_node;
  logic [NODE_W-1:0]     start_node;
  logic                  push_ok;

  assign cfg_ready   = 1'b1;
  assign in_stall    = (state_r != S_LOAD);
  assign out_valid   = out_valid_r;
  assign out_acyclic = out_acyclic_r;

  // input item decode
  assign in_acc       = in_valid && !in_stall;
  assign in_range     = (32'(in_edge_from) < 32'(MAX_NODES)) &&
                        (32'(in_edge_to) < 32'(MAX_NODES));
  assign in_from_node = NODE_W'(in_edge_from);
  assign in_to_node   = NODE_W'(in_edge_to);
  assign res_load     = !out_valid_r || !out_stall;

  // row update for the edge in the write stage, forwarded on a repeated row
  assign adj_merged = (s1_fwd_r ? wr_data_r : adj_rd_data) |
                      ({{(MAX_NODES-1){1'b0}}, 1'b1} << s1_to_r);

  assign {stk_node, stk_cur} = stk_rd_r;
  assign start_node = NODE_W'(start_r);

  // chunked scan for the next successor at or after the cursor
  always_comb begin
    cur_hi     = top_cur_r[CUR_W-1:SCAN_SHIFT];
    chunk_bits = '0;
    for (int c = 0; c < NCHUNK; c++) begin
      if (cur_hi == HI_W'(c)) begin
        chunk_bits = row_r[c*SCAN_W +: SCAN_W];
      end
    end
    chunk_masked = chunk_bits & ({SCAN_W{1'b1}} << top_cur_r[SCAN_SHIFT-1:0]);
    hit_off = '0;
    for (int b = SCAN_W - 1; b >= 0; b--) begin
      if (chunk_masked[b]) begin
        hit_off = SCAN_SHIFT'(b);
      end
    end
    cur_end        = (top_cur_r >= CUR_W'(MAX_NODES));
    last_chunk     = (cur_hi == HI_W'(NCHUNK - 1));
    scan_found     = !cur_end && (|chunk_masked);
    scan_exhausted = cur_end || (!(|chunk_masked) && last_chunk);
    m_cur          = {cur_hi, hit_off};
    m_next         = m_cur + CUR_W'(1);
    next_base      = {cur_hi + HI_W'(1), {SCAN_SHIFT{1'b0}}};
    m_node         = NODE_W'(m_cur);
    push_ok        = scan_found && !on_path_r[m_node] && !done_r[m_node] &&
                     (depth_r != DEP_W'(MAX_NODES));
  end

  // adjacency RAM requests
  always_comb begin
    adj_ctl       = '0;
    adj_rd_addr   = in_from_node;
    adj_ctl.wr_en = s1_vld_r;
    case (state_r)
      S_LOAD: begin
        adj_ctl.rd_en = in_acc;
        adj_rd_addr   = in_from_node;
      end
      S_SEEK: begin
        adj_ctl.rd_en = (start_r != CUR_W'(MAX_NODES)) && !done_r[start_node];
        adj_rd_addr   = start_node;
      end
      S_SCAN: begin
        adj_ctl.rd_en = push_ok;
        adj_rd_addr   = m_node;
      end
      S_POP: begin
        adj_ctl.rd_en = 1'b1;
        adj_rd_addr   = stk_node;
      end
      S_RESULT: begin
        adj_ctl.clr = res_load;
      end
      default: begin
        adj_ctl.rd_en = 1'b0;
      end
    endcase
  end

  dgc_adj_ram #(
    .MAX_NODES (MAX_NODES)
  ) u_adj (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (adj_ctl),
    .rd_addr (adj_rd_addr),
    .wr_addr (s1_from_r),
    .wr_data (adj_merged),
    .rd_data (adj_rd_data)
  );

  // walk stack: parent node and resume cursor
  assign stk_wr_en = (state_r == S_SCAN) && push_ok;
  assign stk_rd_en = (state_r == S_SCAN) && !scan_found && scan_exhausted &&
                     (depth_r != DEP_W'(1));

  always_ff @(posedge clk) begin
    if (stk_wr_en) begin
      stk_mem[NODE_W'(depth_r - DEP_W'(1))] <= {top_node_r, m_next};
    end
    if (stk_rd_en) begin
      stk_rd_r <= stk_mem[NODE_W'(depth_r - DEP_W'(2))];
    end
  end

  // load pipeline write stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s1_fwd_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc && in_has_edge && in_range;
      s1_fwd_r <= s1_vld_r && in_acc && in_has_edge && in_range &&
                  (s1_from_r == in_from_node);
    end
    s1_from_r <= in_from_node;
    s1_to_r   <= in_to_node;
    wr_data_r <= adj_merged;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_courses_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      num_courses_r <= cfg_num_courses;
    end
  end

  // sequencer: batch load, depth-first walk, result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_LOAD;
      edge_seen_r   <= 1'b0;
      on_path_r     <= '0;
      done_r        <= '0;
      depth_r       <= '0;
      start_r       <= '0;
      out_valid_r   <= 1'b0;
      out_acyclic_r <= 1'b0;
      res_r         <= 1'b0;
    end else begin
      // the result state reloads the output register itself
      if (out_valid_r && !out_stall && (state_r != S_RESULT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (in_has_edge) begin
              edge_seen_r <= 1'b1;
            end
            if (in_last_edge) begin
              state_r <= S_FLUSH;
            end
          end
        end
        // last edge is written this cycle
        S_FLUSH: begin
          start_r <= '0;
          if ((num_courses_r <= 7'd1) || !edge_seen_r) begin
            res_r   <= 1'b1;
            state_r <= S_RESULT;
          end else begin
            state_r <= S_SEEK;
          end
        end
        // next unfinished start node
        S_SEEK: begin
          if (start_r == CUR_W'(MAX_NODES)) begin
            res_r   <= 1'b1;
            state_r <= S_RESULT;
          end else if (done_r[start_node]) begin
            start_r <= start_r + CUR_W'(1);
          end else begin
            top_node_r            <= start_node;
            top_cur_r             <= '0;
            depth_r               <= DEP_W'(1);
            on_path_r[start_node] <= 1'b1;
            state_r               <= S_ROW;
          end
        end
        S_ROW: begin
          row_r   <= ROW_W'(adj_rd_data);
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_found) begin
            top_cur_r <= m_next;
            if (on_path_r[m_node]) begin
              res_r   <= 1'b0;
              state_r <= S_RESULT;
            end else if (push_ok) begin
              top_node_r        <= m_node;
              top_cur_r         <= '0;
              depth_r           <= depth_r + DEP_W'(1);
              on_path_r[m_node] <= 1'b1;
              state_r           <= S_ROW;
            end
          end else if (scan_exhausted) begin
            on_path_r[top_node_r] <= 1'b0;
            done_r[top_node_r]    <= 1'b1;
            depth_r               <= depth_r - DEP_W'(1);
            state_r               <= (depth_r == DEP_W'(1)) ? S_SEEK : S_POP;
          end else begin
            top_cur_r <= next_base;
          end
        end
        // resume the parent popped from the stack
        S_POP: begin
          top_node_r <= stk_node;
          top_cur_r  <= stk_cur;
          state_r    <= S_ROW;
        end
        S_RESULT: begin
          if (res_load) begin
            out_valid_r   <= 1'b1;
            out_acyclic_r <= res_r;
            edge_seen_r   <= 1'b0;
            on_path_r     <= '0;
            done_r        <= '0;
            depth_r       <= '0;
            state_r       <= S_LOAD;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a result only appears out of the result state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESULT))
    else $error("result registered outside result state");

  // the node being scanned is always on the current path
  a_top_on_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> on_path_r[top_node_r])
    else $error("scanned node not on path");

  // no edge write still pending once the walk starts
  a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEEK || state_r == S_ROW || state_r == S_SCAN) |-> !s1_vld_r)
    else $error("edge write overlaps the walk");

  // forwarding only follows an edge write to the same row
  a_fwd_chain: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fwd_r |-> (s1_vld_r && $past(s1_vld_r)))
    else $error("forward without a preceding write");

  // stack depth bounded by node count
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (depth_r != '0) && (depth_r <= DEP_W'(MAX_NODES)))
    else $error("stack depth out of range");
`endif

endmodule
